[rtl/slt_pkg.sv]
`default_nettype none

package slt_pkg;

  // operation codes; the unused code is served as a search
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ABSENT    = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_CHK,
    S_DECIDE,
    S_UP_RD,
    S_UP_WR,
    S_INS_WR,
    S_DN_RD,
    S_DN_WR,
    S_DEL_FIN,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;        // capture the input beat, rewind the scan
    logic       rd_scan;     // read entry at scan index
    logic       inc_i;       // advance scan index
    logic       set_present; // record key match at scan index
    logic       jload_count; // shift pointer from entry count
    logic       jload_i;     // shift pointer from scan index
    logic       rd_up;       // read entry below shift pointer
    logic       wr_up;       // write read data at pointer, step down
    logic       rd_dn;       // read entry above shift pointer
    logic       wr_dn;       // write read data at pointer, step up
    logic       wr_key;      // store key at scan index, count up
    logic       dec_count;   // count down after removal
    logic       set_res;     // capture result fields
    logic [1:0] res_status;
    logic       res_found;
    logic       res_pos;     // position is the scan index, else zero
    logic       emit;        // load the output register
  } slt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       at_end;   // scan index reached entry count
    logic       less;     // read entry below key
    logic       equal;    // read entry equals key
    logic       full;
    logic       present;
    logic [1:0] op;
    logic       j_eq_i;   // shift pointer at scan index
    logic       j_last;   // shift pointer at last entry
    logic       out_free; // output register can take a beat
  } slt_sts_t;

endpackage

`default_nettype wire

[rtl/slt_in_if.sv]
`default_nettype none

interface slt_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  operation;
  logic signed [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

[rtl/slt_out_if.sv]
`default_nettype none

interface slt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       found;
  logic [3:0] position;
  logic [4:0] entry_count;

  modport source (output valid, output status, output found, output position,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found, input position,
                  input entry_count, output ready);
endinterface

`default_nettype wire

[rtl/slt_ctrl.sv]
`default_nettype none

module slt_ctrl import slt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire slt_sts_t sts,
  output slt_cmd_t      cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      // lower-bound walk: read the entry at the scan index, then compare it with the key
      S_SCAN: begin
        if (sts.at_end) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt   = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.less) begin
          cmd.inc_i = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          cmd.set_present = 1'b1;
          state_nxt       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts.op)
          OP_INSERT: begin
            if (sts.present) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_DUPLICATE;
              cmd.res_found  = 1'b1;
              cmd.res_pos    = 1'b1;
              state_nxt      = S_RESULT;
            end else if (sts.full) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_FULL;
              state_nxt      = S_RESULT;
            end else begin
              cmd.jload_count = 1'b1;
              state_nxt       = S_UP_RD;
            end
          end
          OP_REMOVE: begin
            if (sts.present) begin
              cmd.jload_i = 1'b1;
              state_nxt   = S_DN_RD;
            end else begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_ABSENT;
              state_nxt      = S_RESULT;
            end
          end
          default: begin
            cmd.set_res = 1'b1;
            if (sts.present) begin
              cmd.res_status = ST_OK;
              cmd.res_found  = 1'b1;
              cmd.res_pos    = 1'b1;
            end else begin
              cmd.res_status = ST_ABSENT;
            end
            state_nxt = S_RESULT;
          end
        endcase
      end
      // open a gap at the insert point, top entry first
      S_UP_RD: begin
        if (sts.j_eq_i) begin
          state_nxt = S_INS_WR;
        end else begin
          cmd.rd_up = 1'b1;
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.wr_up = 1'b1;
        state_nxt = S_UP_RD;
      end
      S_INS_WR: begin
        cmd.wr_key     = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_pos    = 1'b1;
        state_nxt      = S_RESULT;
      end
      // close the gap left by the removed entry
      S_DN_RD: begin
        if (sts.j_last) begin
          state_nxt = S_DEL_FIN;
        end else begin
          cmd.rd_dn = 1'b1;
          state_nxt = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd.wr_dn = 1'b1;
        state_nxt = S_DN_RD;
      end
      S_DEL_FIN: begin
        cmd.dec_count  = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_found  = 1'b1;
        cmd.res_pos    = 1'b1;
        state_nxt      = S_RESULT;
      end
      // wait for room in the output register
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/slt_dpath.sv]
`default_nettype none

module slt_dpath import slt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic        [1:0]  in_operation,
  input  wire logic signed [31:0] in_value,
  input  wire slt_cmd_t           cmd,
  output slt_sts_t                sts,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic             [1:0]  out_status,
  output logic                    out_found,
  output logic             [3:0]  out_position,
  output logic             [4:0]  out_entry_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // entry store, one read and one write port
  logic        [31:0] mem [TABLE_DEPTH];
  logic        [31:0] rd_data_r;
  logic               mem_re;
  logic               mem_we;
  logic      [AW-1:0] rd_addr;
  logic      [AW-1:0] wr_addr;
  logic        [31:0] wr_data;

  logic signed [31:0] key_r;
  logic         [1:0] op_r;
  logic               present_r;
  logic      [CW-1:0] count_r;
  logic      [CW-1:0] i_r;
  logic      [CW-1:0] j_r;
  logic      [CW-1:0] j_dn;
  logic      [CW-1:0] j_up;
  logic        [CW:0] j_up_ext;

  logic         [1:0] res_status_r;
  logic               res_found_r;
  logic      [CW-1:0] res_pos_r;
  logic               out_valid_r;
  logic         [1:0] out_status_r;
  logic               out_found_r;
  logic         [3:0] out_position_r;
  logic         [4:0] out_entry_count_r;
  logic    [CW+3:0]   pos_ext;
  logic    [CW+4:0]   count_ext;

  assign j_dn     = j_r - CW'(1);
  assign j_up     = j_r + CW'(1);
  assign j_up_ext = {1'b0, j_r} + (CW+1)'(1);

  // memory port selection
  always_comb begin
    mem_re  = cmd.rd_scan | cmd.rd_up | cmd.rd_dn;
    mem_we  = cmd.wr_up | cmd.wr_dn | cmd.wr_key;
    rd_addr = i_r[AW-1:0];
    if (cmd.rd_up) begin
      rd_addr = j_dn[AW-1:0];
    end else if (cmd.rd_dn) begin
      rd_addr = j_up[AW-1:0];
    end
    wr_addr = j_r[AW-1:0];
    wr_data = rd_data_r;
    if (cmd.wr_key) begin
      wr_addr = i_r[AW-1:0];
      wr_data = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.wr_key) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.dec_count) begin
      count_r <= count_r - CW'(1);
    end
  end

  // operation registers, scan index and shift pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r     <= in_value;
      op_r      <= in_operation;
      present_r <= 1'b0;
      i_r       <= '0;
    end else begin
      if (cmd.inc_i) begin
        i_r <= i_r + CW'(1);
      end
      if (cmd.set_present) begin
        present_r <= sts.equal;
      end
    end
    if (cmd.jload_count) begin
      j_r <= count_r;
    end else if (cmd.jload_i) begin
      j_r <= i_r;
    end else if (cmd.wr_up) begin
      j_r <= j_dn;
    end else if (cmd.wr_dn) begin
      j_r <= j_up;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_found_r  <= cmd.res_found;
      res_pos_r    <= cmd.res_pos ? i_r : '0;
    end
  end

  assign pos_ext   = {4'b0, res_pos_r};
  assign count_ext = {5'b0, count_r};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r      <= res_status_r;
      out_found_r       <= res_found_r;
      out_position_r    <= pos_ext[3:0];
      out_entry_count_r <= count_ext[4:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_position    = out_position_r;
  assign out_entry_count = out_entry_count_r;

  // status to controller
  always_comb begin
    sts.at_end   = (i_r == count_r);
    sts.less     = ($signed(rd_data_r) < key_r);
    sts.equal    = (rd_data_r == key_r);
    sts.full     = (count_r == CW'(TABLE_DEPTH));
    sts.present  = present_r;
    sts.op       = op_r;
    sts.j_eq_i   = (j_r == i_r);
    sts.j_last   = (j_up_ext >= {1'b0, count_r});
    sts.out_free = ~out_valid_r | out_ready;
  end

endmodule

`default_nettype wire

[rtl/sorted_list_table.sv]
`default_nettype none
// channel   direction  beat contents
// in_chan   sink       operation, value
// out_chan  source     status, found, position, entry_count
//
// One beat at a time. The walk reads each entry below the key and then compares it;
// a search then captures its result. An insert moves the entries above the insert
// point up, top entry first, and writes the key; a remove moves the entries above
// the removed one down and counts down. The result then waits for room in the output.
// Reset clears the entry count and the output valid flag; no clearing pass.
// The next beat is taken while a result waits; its own result waits for room.

module sorted_list_table import slt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  slt_in_if.sink    in_chan,
  slt_out_if.source out_chan
);

  slt_cmd_t cmd;
  slt_sts_t sts;

  // sequencer
  slt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table store and result path
  slt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_chan.operation),
    .in_value        (in_chan.value),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_status      (out_chan.status),
    .out_found       (out_chan.found),
    .out_position    (out_chan.position),
    .out_entry_count (out_chan.entry_count)
  );

endmodule

`default_nettype wire
